>>> src/sfr_pkg.sv
// Shared types, widths and constants of the serial frame receiver.
`default_nettype none
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int CHECK_W     = 16;
  localparam int FRAME_SIZE_W = 6;
  localparam int CFG_IDX_W   = 2;

  // Register reset values
  localparam logic [BYTE_W-1:0]  HEADER_FIRST_RST  = 8'hDE;
  localparam logic [BYTE_W-1:0]  HEADER_SECOND_RST = 8'h5B;
  localparam logic [CHECK_W-1:0] CHECK_SEED_RST    = 16'h1021;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_CHECK_SEED    = 2'd2
  } cfg_index_t;

  // Frame parser phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR     = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHK1    = 3'd4,
    PH_CHK2    = 3'd5
  } parse_phase_t;

  // Emitter states
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_ZERO = 2'd1,
    EM_READ = 2'd2,
    EM_LOAD = 2'd3
  } emit_state_t;

  // Running checksum: rotate left by one, then XOR the byte in
  function automatic logic [CHECK_W-1:0] check_step(input logic [CHECK_W-1:0] c,
                                                    input logic [BYTE_W-1:0]  b);
    check_step = {c[CHECK_W-2:0], c[CHECK_W-1]} ^ {{(CHECK_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage
`default_nettype wire

>>> src/sfr_payload_ram.sv
// Payload store: single-port-write, single-read memory with registered read data.
`default_nettype none
module sfr_payload_ram
  import sfr_pkg::*;
#(
  parameter int DEPTH = 60,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/sfr_parser.sv
// Frame parser: config registers, header hunt, length, payload store writes, checksum.
`default_nettype none
module sfr_parser
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 60,
  parameter int AW          = 6,
  parameter int LW          = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHECK_W-1:0]   cfg_wdata,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  input  wire logic                 in_after_gap,
  input  wire logic                 in_sink_full,
  // payload store write side
  output logic                      ram_we,
  output logic      [AW-1:0]        ram_waddr,
  output logic      [BYTE_W-1:0]    ram_wdata,
  // emitter handoff
  input  wire logic                 emit_busy,
  output logic                      emit_start,
  output logic      [LW-1:0]        emit_len
);

  localparam logic [BYTE_W:0] MAX_LEN = (BYTE_W+1)'(MAX_PAYLOAD);

  logic [BYTE_W-1:0]  hdr_first_r;
  logic [BYTE_W-1:0]  hdr_second_r;
  logic [CHECK_W-1:0] seed_r;

  parse_phase_t       phase_r, phase_nxt, phase_eff;
  logic [LW-1:0]      offset_r, offset_nxt, offset_inc;
  logic [LW-1:0]      length_r, length_nxt;
  logic [CHECK_W-1:0] chk_r, chk_nxt;
  logic [BYTE_W-1:0]  chk_hi_r, chk_hi_nxt;
  logic               accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HEADER_FIRST_RST;
      hdr_second_r <= HEADER_SECOND_RST;
      seed_r       <= CHECK_SEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  hdr_first_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_HEADER_SECOND: hdr_second_r <= cfg_wdata[BYTE_W-1:0];
        CFG_CHECK_SEED:    seed_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input is held off while a frame drains
  assign in_stall = emit_busy;
  assign accept   = in_valid && !in_stall;

  assign offset_inc = offset_r + LW'(1);
  assign ram_waddr  = offset_r[AW-1:0];
  assign ram_wdata  = in_rx_byte;
  assign emit_len   = length_r;

  // Phase register and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      offset_r <= '0;
      length_r <= '0;
      chk_r    <= '0;
      chk_hi_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      chk_r    <= chk_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

  // Next phase and store writes
  always_comb begin
    phase_eff  = in_after_gap ? PH_IDLE : phase_r;
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    chk_nxt    = chk_r;
    chk_hi_nxt = chk_hi_r;
    ram_we     = 1'b0;
    emit_start = 1'b0;
    if (accept) begin
      case (phase_eff)
        PH_IDLE: begin
          phase_nxt = (in_rx_byte == hdr_first_r) ? PH_HDR : PH_IDLE;
        end
        PH_HDR: begin
          phase_nxt = (in_rx_byte == hdr_second_r) ? PH_SIZE : PH_IDLE;
        end
        PH_SIZE: begin
          if (in_sink_full || ({1'b0, in_rx_byte} > MAX_LEN)) begin
            phase_nxt = PH_IDLE;
          end else begin
            length_nxt = LW'(in_rx_byte);
            offset_nxt = '0;
            chk_nxt    = check_step(seed_r, in_rx_byte);
            phase_nxt  = (in_rx_byte == '0) ? PH_CHK1 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          chk_nxt    = check_step(chk_r, in_rx_byte);
          ram_we     = 1'b1;
          offset_nxt = offset_inc;
          phase_nxt  = (offset_inc == length_r) ? PH_CHK1 : PH_PAYLOAD;
        end
        PH_CHK1: begin
          chk_hi_nxt = in_rx_byte;
          phase_nxt  = PH_CHK2;
        end
        PH_CHK2: begin
          emit_start = ({chk_hi_r, in_rx_byte} == chk_r);
          phase_nxt  = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/sfr_emitter.sv
// Frame emitter: reads the stored payload back and drives the result register.
`default_nettype none
module sfr_emitter
  import sfr_pkg::*;
#(
  parameter int AW = 6,
  parameter int LW = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    emit_start,
  input  wire logic [LW-1:0]           emit_len,
  output logic                         emit_busy,
  // payload store read side
  output logic                         ram_re,
  output logic      [AW-1:0]           ram_raddr,
  input  wire logic [BYTE_W-1:0]       ram_rdata,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [BYTE_W-1:0]       out_payload_byte,
  output logic      [FRAME_SIZE_W-1:0] out_frame_size,
  output logic      [FRAME_SIZE_W-1:0] out_byte_index,
  output logic                         out_last
);

  emit_state_t             state_r, state_nxt;
  logic [LW-1:0]           idx_r, idx_nxt, idx_inc;
  logic [LW-1:0]           len_r, len_nxt;
  logic                    valid_r, valid_nxt;
  logic                    out_free, load;
  logic [BYTE_W-1:0]       byte_nxt, byte_r;
  logic [FRAME_SIZE_W-1:0] size_nxt, size_r, index_nxt, index_r;
  logic                    last_nxt, last_r;

  assign out_free  = !valid_r || !out_stall;
  assign idx_inc   = idx_r + LW'(1);
  assign ram_raddr = idx_r[AW-1:0];
  assign emit_busy = (state_r != EM_IDLE);

  assign out_valid        = valid_r;
  assign out_payload_byte = byte_r;
  assign out_frame_size   = size_r;
  assign out_byte_index   = index_r;
  assign out_last         = last_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      valid_r <= 1'b0;
      idx_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      size_r  <= size_nxt;
      index_r <= index_nxt;
      last_r  <= last_nxt;
    end
  end

  // Each payload byte: a memory read once the result register is free, then the result load
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    ram_re    = 1'b0;
    load      = 1'b0;
    byte_nxt  = ram_rdata;
    size_nxt  = FRAME_SIZE_W'(len_r);
    index_nxt = FRAME_SIZE_W'(idx_r);
    last_nxt  = (idx_inc == len_r);
    case (state_r)
      EM_IDLE: begin
        if (emit_start) begin
          len_nxt   = emit_len;
          idx_nxt   = '0;
          state_nxt = (emit_len == '0) ? EM_ZERO : EM_READ;
        end
      end
      EM_ZERO: begin
        // empty frame: a single marker result
        if (out_free) begin
          load      = 1'b1;
          byte_nxt  = '0;
          size_nxt  = '0;
          index_nxt = '0;
          last_nxt  = 1'b1;
          state_nxt = EM_IDLE;
        end
      end
      EM_READ: begin
        if (out_free) begin
          ram_re    = 1'b1;
          state_nxt = EM_LOAD;
        end
      end
      EM_LOAD: begin
        // result register is empty here: it was free when the read went out
        load      = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = (idx_inc == len_r) ? EM_IDLE : EM_READ;
      end
      default: state_nxt = EM_IDLE;
    endcase
    valid_nxt = load ? 1'b1 : (valid_r && out_stall);
  end

endmodule
`default_nettype wire

>>> src/serial_frame_receiver.sv
// Top level of the serial frame receiver.
`default_nettype none
// Parses a received byte stream into frames of the form header_first,
// header_second, length, payload, checksum high, checksum low. The checksum
// starts at check_seed and, for the length byte and each payload byte, is
// rotated left by one and XORed with the byte. An idle gap flag restarts the
// header hunt; an oversized length or a full sink drops the frame. While a
// frame is being parsed, one input byte is taken per clock. After the last
// checksum byte of a good frame the input is stalled while the frame drains:
// each payload byte needs a read of the payload memory, then the load of
// the result register; an empty frame needs a single marker load. The drain
// waits on result stalls. The payload memory needs no clearing after reset.
module serial_frame_receiver
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 60
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CHECK_W-1:0]      cfg_wdata,
  // received bytes
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [BYTE_W-1:0]       in_rx_byte,
  input  wire logic                    in_after_gap,
  input  wire logic                    in_sink_full,
  // frame payload bytes
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [BYTE_W-1:0]       out_payload_byte,
  output logic      [FRAME_SIZE_W-1:0] out_frame_size,
  output logic      [FRAME_SIZE_W-1:0] out_byte_index,
  output logic                         out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  logic              emit_start, emit_busy;
  logic [LW-1:0]     emit_len;

  sfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .LW          (LW)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .in_after_gap (in_after_gap),
    .in_sink_full (in_sink_full),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .emit_busy    (emit_busy),
    .emit_start   (emit_start),
    .emit_len     (emit_len)
  );

  sfr_payload_ram #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  sfr_emitter #(
    .AW (AW),
    .LW (LW)
  ) u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit_start       (emit_start),
    .emit_len         (emit_len),
    .emit_busy        (emit_busy),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_size   (out_frame_size),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire
